// ===== rtl/core/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants of the indexed list store: command and status
// codes, request and response payloads, and the control word for the cells.
// ----------------------------------------------------------------------------
package ils_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int CMD_W      = 3;
   localparam int STATUS_W   = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_GET    = 3'd2,
      CMD_SET    = 3'd3,
      CMD_INSERT = 3'd4,
      CMD_REMOVE = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // What each cell does with its word when a request goes through.
   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_WRITE  = 2'd1,  // load the value at pos
      ACT_INSERT = 2'd2,  // load the value at pos, cells above take the left word
      ACT_REMOVE = 2'd3   // cells at and above pos take the right word
   } action_type;

   typedef struct packed {
      action_type         action;
      logic [CNT_W-1:0]   pos;
   } ctl_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [4:0]         index;
      logic [31:0]        value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [31:0]         data;
      logic [4:0]          count;
   } rsp_type;

   typedef struct packed {
      status_type          status;
      ctl_type             ctl;
      logic [CNT_W-1:0]    count_next;
      logic                rd_en;
      logic [SLOT_W-1:0]   rd_addr;
   } dec_type;

endpackage

// ===== rtl/core/ils_cell.sv =====
// ----------------------------------------------------------------------------
// ils_cell
// One entry of the list. Holds a word, loads the request value, or takes the
// word of its lower or upper neighbor when the list shifts.
// ----------------------------------------------------------------------------
module ils_cell (
   input  logic                            clock,
   input  logic                            en,
   input  logic [ils_pkg::SLOT_W-1:0]      slot,
   input  ils_pkg::ctl_type                ctl,
   input  logic [ils_pkg::DATA_WIDTH-1:0]  wr_value,
   input  logic [ils_pkg::DATA_WIDTH-1:0]  left_word,
   input  logic [ils_pkg::DATA_WIDTH-1:0]  right_word,
   output logic [ils_pkg::DATA_WIDTH-1:0]  word
);

   logic [ils_pkg::DATA_WIDTH-1:0] word_ff;
   logic [ils_pkg::DATA_WIDTH-1:0] word_in;
   logic [ils_pkg::CNT_W-1:0]      slot_ext;

   assign slot_ext = ils_pkg::CNT_W'(slot);

   always_comb begin
      word_in = word_ff;
      case (ctl.action)
         ils_pkg::ACT_WRITE: begin
            if (slot_ext == ctl.pos) word_in = wr_value;
         end
         ils_pkg::ACT_INSERT: begin
            if (slot_ext == ctl.pos)     word_in = wr_value;
            else if (slot_ext > ctl.pos) word_in = left_word;
         end
         ils_pkg::ACT_REMOVE: begin
            if (slot_ext >= ctl.pos) word_in = right_word;
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// ===== rtl/core/ils_decode.sv =====
// ----------------------------------------------------------------------------
// ils_decode
// Checks a request against the current count and produces the status, the
// cell control word, the read address and the next count.
// ----------------------------------------------------------------------------
module ils_decode (
   input  ils_pkg::req_type              req,
   input  logic [ils_pkg::CNT_W-1:0]     held,
   output ils_pkg::dec_type              dec
);

   logic [ils_pkg::CNT_W-1:0] idx;
   logic                      full;
   logic                      empty;

   assign idx   = ils_pkg::CNT_W'(req.index);
   assign full  = (held >= ils_pkg::CNT_W'(ils_pkg::CAPACITY));
   assign empty = (held == '0);

   always_comb begin
      dec.status     = ils_pkg::ST_OK;
      dec.ctl.action = ils_pkg::ACT_NONE;
      dec.ctl.pos    = idx;
      dec.count_next = held;
      dec.rd_en      = 1'b0;
      dec.rd_addr    = idx[ils_pkg::SLOT_W-1:0];
      unique case (req.command)
         ils_pkg::CMD_PUSH: begin
            if (full) begin
               dec.status = ils_pkg::ST_FULL;
            end else begin
               dec.ctl.action = ils_pkg::ACT_WRITE;
               dec.ctl.pos    = held;
               dec.count_next = held + 1'b1;
            end
         end
         ils_pkg::CMD_POP: begin
            if (empty) begin
               dec.status = ils_pkg::ST_UNDERFLOW;
            end else begin
               dec.rd_en      = 1'b1;
               dec.rd_addr    = ils_pkg::SLOT_W'(held - 1'b1);
               dec.count_next = held - 1'b1;
            end
         end
         ils_pkg::CMD_GET: begin
            if (idx >= held) dec.status = ils_pkg::ST_BAD_INDEX;
            else             dec.rd_en  = 1'b1;
         end
         ils_pkg::CMD_SET: begin
            if (idx >= held) dec.status     = ils_pkg::ST_BAD_INDEX;
            else             dec.ctl.action = ils_pkg::ACT_WRITE;
         end
         ils_pkg::CMD_INSERT: begin
            if (idx > held) begin
               dec.status = ils_pkg::ST_BAD_INDEX;
            end else if (full) begin
               dec.status = ils_pkg::ST_FULL;
            end else begin
               dec.ctl.action = ils_pkg::ACT_INSERT;
               dec.count_next = held + 1'b1;
            end
         end
         ils_pkg::CMD_REMOVE: begin
            if (idx >= held) begin
               dec.status = ils_pkg::ST_BAD_INDEX;
            end else begin
               dec.rd_en      = 1'b1;
               dec.ctl.action = ils_pkg::ACT_REMOVE;
               dec.count_next = held - 1'b1;
            end
         end
         default: dec.status = ils_pkg::ST_OK;
      endcase
   end

endmodule

// ===== rtl/core/indexed_list_store.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store
// Fixed-capacity ordered list with push, pop, get, set, insert and remove.
// ----------------------------------------------------------------------------
//  channel   direction  ports                          content
//  request   in         req_valid req_ready req_data   command, index, value
//  response  out        rsp_valid rsp_ready rsp_data   status, data, count
//
//  One request per cycle: every command, insert and remove included, finishes
//  in the cycle it is accepted, since each cell of the chain loads, holds or
//  takes a neighbor's word in parallel. The response is held in a register.
//  A new request is taken whenever the response register is empty or is being
//  drained in the same cycle. Reset empties the list (count zero) and drops
//  any pending response; entry words are not cleared.
// ----------------------------------------------------------------------------
module indexed_list_store (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ils_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ils_pkg::rsp_type rsp_data
);

   localparam int N = ils_pkg::CAPACITY;
   localparam int W = ils_pkg::DATA_WIDTH;

   logic [ils_pkg::CNT_W-1:0] held_ff;
   logic [ils_pkg::CNT_W-1:0] held_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   ils_pkg::rsp_type          rsp_data_ff;
   ils_pkg::rsp_type          rsp_data_in;

   logic                      req_fire;
   ils_pkg::dec_type          dec;
   logic [W-1:0]              words [N];
   logic [W-1:0]              rd_word;

   // Accept while the response slot is free or emptying this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   ils_decode u_decode (
      .req  (req_data),
      .held (held_ff),
      .dec  (dec)
   );

   // Chain of cells: cell 0 sees zero below, the top cell sees zero above.
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [W-1:0] left_word;
      logic [W-1:0] right_word;

      if (i == 0) begin : g_low
         assign left_word = '0;
      end else begin : g_mid_low
         assign left_word = words[i-1];
      end

      if (i == N - 1) begin : g_high
         assign right_word = '0;
      end else begin : g_mid_high
         assign right_word = words[i+1];
      end

      ils_cell u_cell (
         .clock      (clock),
         .en         (req_fire),
         .slot       (ils_pkg::SLOT_W'(i)),
         .ctl        (dec.ctl),
         .wr_value   (req_data.value[W-1:0]),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (words[i])
      );
   end

   // Read the old word: pop, get and remove all see the list before the update.
   assign rd_word = words[dec.rd_addr];

   always_comb begin
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (req_fire) begin
         held_in            = dec.count_next;
         rsp_valid_in       = 1'b1;
         rsp_data_in.status = dec.status;
         rsp_data_in.data   = dec.rd_en ? 32'(rd_word) : '0;
         rsp_data_in.count  = 5'(dec.count_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Count never passes capacity.
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= ils_pkg::CNT_W'(N))
      else $error("held count above capacity");

   // Every accepted request leaves a response behind.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request without response");

   // Reported count tracks the stored count.
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_data_ff.count == 5'(held_ff)))
      else $error("response count differs from held count");

   // A full status only on a full list, and it leaves the count alone.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (req_fire && dec.status == ils_pkg::ST_FULL) |->
         (held_ff == ils_pkg::CNT_W'(N) && dec.count_next == held_ff))
      else $error("full status on a list that is not full");

endmodule
